FILE: hw/rtl/tsg_pkg.sv
// Shared constants, types and the sine table function for the test signal generator.
package tsg_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int TABLE_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 18;

  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 5;

  localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;
  localparam logic [31:0] LFSR_SEED   = 32'hACE1_ACE1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] REG_ENABLES    = 3'd0;
  localparam logic [2:0] REG_SINE_STEP  = 3'd1;
  localparam logic [2:0] REG_SINE_AMP   = 3'd2;
  localparam logic [2:0] REG_IMP_PERIOD = 3'd3;
  localparam logic [2:0] REG_IMP_AMP    = 3'd4;
  localparam logic [2:0] REG_NOISE_AMP  = 3'd5;
  localparam logic [2:0] REG_MOD_STEP   = 3'd6;
  localparam logic [2:0] REG_MOD_DEPTH  = 3'd7;

  typedef struct packed {
    logic [3:0]  enables;
    logic [31:0] sine_step;
    logic [14:0] sine_amp;
    logic [31:0] imp_period;
    logic [14:0] imp_amp;
    logic [14:0] noise_amp;
    logic [31:0] mod_step;
    logic [15:0] mod_depth;
  } tsg_cfg_t;

  typedef struct packed {
    logic restart;
  } tsg_job_t;

  // Entry k of a full-cycle Q1.15 sine table with 2**tbits entries.
  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                    input int unsigned tbits);
    int unsigned half;
    int unsigned quarter;
    int unsigned h;
    int unsigned m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prd;
    longint      sum;
    half    = 1 << (tbits - 1);
    quarter = 1 << (tbits - 2);
    h       = k & (half - 1);
    m       = (h <= quarter) ? h : (half - h);
    x       = (64'(m) * HALF_PI_Q30) >> (tbits - 2);
    x2      = (x * x) >> 30;
    term    = x;
    sum     = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      prd = (term * x2) >> 30;
      unique case (n)
        1:       term = prd / 64'd6;
        2:       term = prd / 64'd20;
        3:       term = prd / 64'd42;
        4:       term = prd / 64'd72;
        5:       term = prd / 64'd110;
        6:       term = prd / 64'd156;
        default: term = prd / 64'd210;
      endcase
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (sum > 32767) begin
      sum = 32767;
    end
    sine_entry = (k >= half) ? -16'(sum) : 16'(sum);
  endfunction

endpackage

FILE: hw/rtl/tsg_in_if.sv
// Input channel carrying one restart flag per item.
interface tsg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

FILE: hw/rtl/tsg_out_if.sv
// Result channel carrying one signed sample per item.
interface tsg_out_if #(
  parameter int SAMPLE_BITS = tsg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/tsg_cfg.sv
// APB register file holding the generator configuration.
module tsg_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output tsg_pkg::tsg_cfg_t         cfg
);

  tsg_pkg::tsg_cfg_t cfg_r;
  tsg_pkg::tsg_cfg_t cfg_nxt;
  logic              wr_en;
  logic [2:0]        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[tsg_pkg::ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        tsg_pkg::REG_ENABLES:    cfg_nxt.enables    = pwdata[3:0];
        tsg_pkg::REG_SINE_STEP:  cfg_nxt.sine_step  = pwdata;
        tsg_pkg::REG_SINE_AMP:   cfg_nxt.sine_amp   = pwdata[14:0];
        tsg_pkg::REG_IMP_PERIOD: cfg_nxt.imp_period = pwdata;
        tsg_pkg::REG_IMP_AMP:    cfg_nxt.imp_amp    = pwdata[14:0];
        tsg_pkg::REG_NOISE_AMP:  cfg_nxt.noise_amp  = pwdata[14:0];
        tsg_pkg::REG_MOD_STEP:   cfg_nxt.mod_step   = pwdata;
        tsg_pkg::REG_MOD_DEPTH:  cfg_nxt.mod_depth  = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tsg_pkg::REG_ENABLES:    prdata = 32'(cfg_r.enables);
      tsg_pkg::REG_SINE_STEP:  prdata = cfg_r.sine_step;
      tsg_pkg::REG_SINE_AMP:   prdata = 32'(cfg_r.sine_amp);
      tsg_pkg::REG_IMP_PERIOD: prdata = cfg_r.imp_period;
      tsg_pkg::REG_IMP_AMP:    prdata = 32'(cfg_r.imp_amp);
      tsg_pkg::REG_NOISE_AMP:  prdata = 32'(cfg_r.noise_amp);
      tsg_pkg::REG_MOD_STEP:   prdata = cfg_r.mod_step;
      tsg_pkg::REG_MOD_DEPTH:  prdata = 32'(cfg_r.mod_depth);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{imp_period: 32'd1, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hw/rtl/tsg_front.sv
// Front end that accepts items and holds them in a short queue for the sample engine.
module tsg_front (
  input  logic              clk,
  input  logic              rst_n,
  tsg_in_if.sink            in_stream,
  output logic              q_valid,
  output tsg_pkg::tsg_job_t q_job,
  input  logic              q_pop
);

  localparam int DEPTH = tsg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsg_pkg::tsg_job_t queue_r [DEPTH];
  tsg_pkg::tsg_job_t job_in;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              push;

  assign job_in.restart  = in_stream.restart;
  assign in_stream.ready = (cnt_r != CNT_W'(DEPTH));
  assign push            = in_stream.valid && in_stream.ready;
  assign q_valid         = (cnt_r != '0);
  assign q_job           = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("Queue popped while empty.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("Queue count exceeds its depth.");

endmodule

FILE: hw/rtl/tsg_back.sv
// Sample engine that sums sine, impulse and noise sources and applies modulation.
module tsg_back #(
  parameter int PHASE_BITS  = tsg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS  = tsg_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = tsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tsg_pkg::tsg_cfg_t cfg,
  input  logic              q_valid,
  input  tsg_pkg::tsg_job_t q_job,
  output logic              q_pop,
  tsg_out_if.source         out_stream
);

  localparam int TBL_SIZE = 1 << TABLE_BITS;
  localparam int ACC_W    = 19;
  localparam int MUL_A_W  = 19;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int FIN_W    = 21;
  localparam int SAT_W    = (SAMPLE_BITS > FIN_W) ? SAMPLE_BITS : FIN_W;
  localparam logic signed [SAT_W-1:0] SAT_MAX =
    SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic [15:0] DEPTH_FULL = 16'd32768;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NOISE = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_FAC   = 3'd3;
  localparam logic [2:0] ST_AM    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [PHASE_BITS-1:0]         sine_phase_r;
  logic [PHASE_BITS-1:0]         sine_phase_nxt;
  logic [PHASE_BITS-1:0]         mod_phase_r;
  logic [PHASE_BITS-1:0]         mod_phase_nxt;
  logic [PHASE_BITS-1:0]         sine_ph_eff;
  logic [PHASE_BITS-1:0]         mod_ph_eff;
  logic [31:0]                   imp_cnt_r;
  logic [31:0]                   imp_cnt_nxt;
  logic [31:0]                   imp_cnt_eff;
  logic                          imp_hit;
  logic [31:0]                   lfsr_r;
  logic [31:0]                   lfsr_nxt;
  logic [31:0]                   lfsr_step;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [16:0]            f_r;
  logic signed [16:0]            f_nxt;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      mul_res;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [15:0]            sine_rom [TBL_SIZE];
  logic [TABLE_BITS-1:0]         tbl_idx;
  logic signed [15:0]            tbl_r;
  logic [15:0]                   depth;
  logic signed [15:0]            noise_u;
  logic signed [FIN_W-1:0]       fin_val;
  logic signed [SAT_W-1:0]       fin_ext;
  logic signed [SAT_W-1:0]       sat_val;
  logic                          out_load;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  for (genvar k = 0; k < TBL_SIZE; k++) begin : g_rom
    assign sine_rom[k] = tsg_pkg::sine_entry(k, TABLE_BITS);
  end

  assign q_pop       = (state_r == ST_IDLE) && q_valid;
  assign sine_ph_eff = q_job.restart ? '0 : sine_phase_r;
  assign mod_ph_eff  = q_job.restart ? '0 : mod_phase_r;
  assign imp_cnt_eff = q_job.restart ? '0 : imp_cnt_r;
  assign imp_hit     = (imp_cnt_eff >= cfg.imp_period);
  assign lfsr_step   = {1'b0, lfsr_r[31:1]} ^ (lfsr_r[0] ? tsg_pkg::LFSR_TAPS : 32'd0);
  assign depth       = (cfg.mod_depth > DEPTH_FULL) ? DEPTH_FULL : cfg.mod_depth;
  assign noise_u     = signed'({~lfsr_step[31], lfsr_step[30:16]});

  assign tbl_idx = (state_r == ST_IDLE) ? sine_ph_eff[PHASE_BITS-1 -: TABLE_BITS]
                                        : mod_phase_r[PHASE_BITS-1 -: TABLE_BITS];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_IDLE: begin
        mul_a = signed'(MUL_A_W'(cfg.noise_amp));
        mul_b = MUL_B_W'(noise_u);
      end
      ST_NOISE: begin
        mul_a = signed'(MUL_A_W'(cfg.sine_amp));
        mul_b = MUL_B_W'(tbl_r);
      end
      ST_MOD: begin
        mul_a = signed'(MUL_A_W'(depth));
        mul_b = MUL_B_W'(tbl_r);
      end
      ST_AM: begin
        mul_a = acc_r;
        mul_b = f_r;
      end
      default: begin
      end
    endcase
  end

  assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign fin_val = cfg.enables[3] ? FIN_W'(prod_r >>> 15) : FIN_W'(acc_r);
  assign fin_ext = SAT_W'(fin_val);

  always_comb begin
    priority if (fin_ext > SAT_MAX) begin
      sat_val = SAT_MAX;
    end else if (fin_ext < SAT_MIN) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = fin_ext;
    end
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_stream.ready);

  always_comb begin
    state_nxt      = state_r;
    sine_phase_nxt = sine_phase_r;
    mod_phase_nxt  = mod_phase_r;
    imp_cnt_nxt    = imp_cnt_r;
    lfsr_nxt       = lfsr_r;
    acc_nxt        = acc_r;
    f_nxt          = f_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          sine_phase_nxt = cfg.enables[0] ? sine_ph_eff + PHASE_BITS'(cfg.sine_step)
                                          : sine_ph_eff;
          mod_phase_nxt  = mod_ph_eff;
          if (cfg.enables[1]) begin
            imp_cnt_nxt = imp_hit ? 32'd1 : imp_cnt_eff + 32'd1;
          end else begin
            imp_cnt_nxt = imp_cnt_eff;
          end
          acc_nxt = (cfg.enables[1] && imp_hit) ? signed'(ACC_W'(cfg.imp_amp)) : '0;
          if (cfg.enables[2]) begin
            lfsr_nxt = lfsr_step;
          end
          state_nxt = ST_NOISE;
        end
      end
      ST_NOISE: begin
        if (cfg.enables[2]) begin
          acc_nxt = acc_r + ACC_W'(prod_r >>> 16);
        end
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (cfg.enables[0]) begin
          acc_nxt = acc_r + ACC_W'(prod_r >>> 15);
        end
        if (cfg.enables[3]) begin
          mod_phase_nxt = mod_phase_r + PHASE_BITS'(cfg.mod_step);
          state_nxt     = ST_FAC;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_FAC: begin
        f_nxt     = 17'sd32768 - signed'(17'(depth)) + 17'(prod_r >>> 16);
        state_nxt = ST_AM;
      end
      ST_AM: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    f_r   <= f_nxt;
    tbl_r <= sine_rom[tbl_idx];
    if (state_r != ST_FAC && state_r != ST_OUT) begin
      prod_r <= mul_res;
    end
    if (out_load) begin
      out_sample_r <= SAMPLE_BITS'(sat_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sine_phase_r <= '0;
      mod_phase_r  <= '0;
      imp_cnt_r    <= '0;
      lfsr_r       <= tsg_pkg::LFSR_SEED;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sine_phase_r <= sine_phase_nxt;
      mod_phase_r  <= mod_phase_nxt;
      imp_cnt_r    <= imp_cnt_nxt;
      lfsr_r       <= lfsr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_stream.valid  = out_valid_r;
  assign out_stream.sample = out_sample_r;

  a_noise_then_mod: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NOISE |=> state_r == ST_MOD)
    else $error("Noise step was not followed by the modulation step.");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("Noise LFSR reached the all-zero state.");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_AM |-> (f_r <= 17'sd32768) && (f_r >= -17'sd16384))
    else $error("Modulation factor out of range.");

  a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("Result load did not return the engine to idle.");

endmodule

FILE: hw/rtl/test_signal_generator_unit.sv
// Top level of the test signal generator: register file, input queue and sample engine.
// An item leaves the queue and passes the engine states idle, noise, mod and out; with
// modulation enabled, fac and am lie between mod and out. One item at a time steps the
// single shared multiplier through the sources; the next is popped only back in idle.
// Reset is synchronous: phases and impulse counter clear, the LFSR loads its seed, the
// queue empties and the configuration registers clear, but the impulse period resets to 1.
module test_signal_generator_unit #(
  parameter int PHASE_BITS  = tsg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS  = tsg_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = tsg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tsg_in_if.sink                     in_stream,
  tsg_out_if.source                  out_stream,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  tsg_pkg::tsg_cfg_t cfg;
  tsg_pkg::tsg_job_t q_job;
  logic              q_valid;
  logic              q_pop;

  tsg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop)
  );

  tsg_back #(
    .PHASE_BITS  (PHASE_BITS),
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule
